/* src/adcn_pkg.sv */
// package: shared types, constants and status codes of the axis normalizer
`timescale 1ns / 1ps
package adcn_pkg;

    localparam int CHANNELS = 128;
    localparam int IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CHAN_W   = 8;
    localparam int VAL_W    = 32;
    localparam int MAP_W    = 18;
    localparam int QUO_W    = 16;
    localparam int CNT_W    = $clog2(QUO_W + 1);

    localparam logic [CHAN_W:0] CHAN_LIM = (CHAN_W + 1)'(CHANNELS);

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_LOAD   = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_CHAN  = 2'd1;
    localparam logic [1:0] ST_BAD_ORDER = 2'd2;

    localparam logic signed [VAL_W-1:0] Q16_ONE     = 32'sd65536;
    localparam logic signed [VAL_W-1:0] Q16_NEG_ONE = -32'sd65536;
    localparam logic signed [MAP_W-1:0] MAP_ONE     = 18'sd65536;
    localparam logic signed [MAP_W-1:0] MAP_NEG_ONE = -18'sd65536;
    localparam logic signed [MAP_W-1:0] MAP_ZERO    = 18'sd0;

    typedef struct packed {
        logic                    kind;
        logic [CHAN_W-1:0]       chan;
        logic signed [VAL_W-1:0] sample;
        logic signed [VAL_W-1:0] clip_min;
        logic signed [VAL_W-1:0] zero_low;
        logic signed [VAL_W-1:0] zero_high;
        logic signed [VAL_W-1:0] clip_max;
    } t_in_req;

    typedef struct packed {
        logic signed [MAP_W-1:0] mapped;
        logic [1:0]              status;
    } t_out_rsp;

    typedef struct packed {
        logic signed [VAL_W-1:0] mn;
        logic signed [VAL_W-1:0] zl;
        logic signed [VAL_W-1:0] zh;
        logic signed [VAL_W-1:0] mx;
    } t_row;

    localparam t_row ROW_RESET = '{mn: Q16_NEG_ONE, zl: '0, zh: '0, mx: Q16_ONE};

endpackage

/* src/analog_deadzone_clip_normalizer_unit.sv */
// top level: sequencer, clip checks, table and shared divider of the axis normalizer
//
//   channel | direction | payload   | handshake
//   request | in        | t_in_req  | i_valid, o_stall
//   result  | out       | t_out_rsp | o_valid, i_stall
//
// a sample between a deadzone edge and a clip point has its result set by the 16 steps
// of the one-bit-per-cycle divider before o_valid; loads, errors and clipped or deadzone
// samples skip the divider
// one request at a time: o_stall is high from accept until the result is registered
// a stalled result holds in the output register while the next request is accepted
// reset clears control state and marks every table row as holding the reset points
`timescale 1ns / 1ps
module analog_deadzone_clip_normalizer_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  adcn_pkg::t_in_req   i_req,
    output logic                o_stall,
    output logic                o_valid,
    output adcn_pkg::t_out_rsp  o_rsp,
    input  logic                i_stall
);
    import adcn_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EVAL = 4'b0010,
        S_DIV  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state   r_state, n_state;
    t_in_req  r_req;
    t_out_rsp r_res, n_res;
    logic     r_neg, n_neg;
    logic     r_ovalid;
    t_out_rsp r_out;

    t_row              row;
    t_row              wrow;
    logic              tbl_we;
    logic              div_start;
    logic              div_done;
    logic [VAL_W-1:0]  div_num;
    logic [VAL_W-1:0]  div_den;
    logic [QUO_W-1:0]  div_quo;

    logic                    bad_chan;
    logic                    bad_order;
    logic                    upper;
    logic signed [VAL_W-1:0] v;
    logic signed [VAL_W-1:0] na, nb, da, db;
    logic [VAL_W:0]          num_full, den_full;
    logic signed [MAP_W-1:0] quo_ext;

    assign wrow = '{mn: r_req.clip_min, zl: r_req.zero_low,
                    zh: r_req.zero_high, mx: r_req.clip_max};

    adcn_table u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (tbl_we),
        .i_waddr (r_req.chan[IDX_W-1:0]),
        .i_wrow  (wrow),
        .i_raddr (i_req.chan[IDX_W-1:0]),
        .o_rrow  (row)
    );

    adcn_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    assign v         = r_req.sample;
    assign bad_chan  = {1'b0, r_req.chan} >= CHAN_LIM;
    assign bad_order = (r_req.zero_low < r_req.clip_min)
                    || (r_req.zero_high < r_req.zero_low)
                    || (r_req.clip_max < r_req.zero_high);
    assign upper     = v > row.zl;

    // upper side: (v - zh) / (mx - zh), lower side: (zl - v) / (zl - mn)
    always_comb begin
        if (upper) begin
            na = v;
            nb = row.zh;
            da = row.mx;
            db = row.zh;
        end else begin
            na = row.zl;
            nb = v;
            da = row.zl;
            db = row.mn;
        end
    end

    assign num_full = {na[VAL_W-1], na} - {nb[VAL_W-1], nb};
    assign den_full = {da[VAL_W-1], da} - {db[VAL_W-1], db};
    assign div_num  = num_full[VAL_W-1:0];
    assign div_den  = den_full[VAL_W-1:0];
    assign quo_ext  = {{(MAP_W - QUO_W){1'b0}}, div_quo};

    always_comb begin
        n_state   = r_state;
        n_res     = r_res;
        n_neg     = r_neg;
        tbl_we    = 1'b0;
        div_start = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                n_state      = S_DONE;
                n_res.mapped = MAP_ZERO;
                n_res.status = ST_OK;
                if (bad_chan) begin
                    n_res.status = ST_BAD_CHAN;
                end else if (r_req.kind == KIND_LOAD) begin
                    if (bad_order) begin
                        n_res.status = ST_BAD_ORDER;
                    end else begin
                        tbl_we = 1'b1;
                    end
                end else if (v >= row.zl && v <= row.zh) begin
                    n_res.mapped = MAP_ZERO;
                end else if (v <= row.mn) begin
                    n_res.mapped = MAP_NEG_ONE;
                end else if (v >= row.mx) begin
                    n_res.mapped = MAP_ONE;
                end else begin
                    div_start = 1'b1;
                    n_neg     = !upper;
                    n_state   = S_DIV;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_res.mapped = r_neg ? -quo_ext : quo_ext;
                    n_state      = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_ovalid || !i_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_req <= i_req;
        end
        r_res <= n_res;
        r_neg <= n_neg;
        if (r_state == S_DONE && (!r_ovalid || !i_stall)) begin
            r_out <= r_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DONE && (!r_ovalid || !i_stall)) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_ovalid;
    assign o_rsp   = r_out;

endmodule

/* src/adcn_table.sv */
// clip point table: one row per channel, registered read, valid bit per row
`timescale 1ns / 1ps
module adcn_table (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_we,
    input  logic [adcn_pkg::IDX_W-1:0] i_waddr,
    input  adcn_pkg::t_row            i_wrow,
    input  logic [adcn_pkg::IDX_W-1:0] i_raddr,
    output adcn_pkg::t_row            o_rrow
);
    import adcn_pkg::*;

    t_row             r_mem [CHANNELS];
    logic [CHANNELS-1:0] r_valid;
    t_row             r_rdata;
    logic             r_rvalid;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wrow;
        end
        r_rdata <= r_mem[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rvalid <= 1'b0;
        end else begin
            if (i_we) begin
                r_valid[i_waddr] <= 1'b1;
            end
            r_rvalid <= r_valid[i_raddr];
        end
    end

    // rows never loaded read as the reset points
    assign o_rrow = r_rvalid ? r_rdata : ROW_RESET;

endmodule

/* src/adcn_div.sv */
// restoring divider: one quotient bit per cycle of (num << 16) / den, num < den
`timescale 1ns / 1ps
module adcn_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [adcn_pkg::VAL_W-1:0] i_num,
    input  logic [adcn_pkg::VAL_W-1:0] i_den,
    output logic                       o_done,
    output logic [adcn_pkg::QUO_W-1:0] o_quo
);
    import adcn_pkg::*;

    logic [VAL_W:0]   r_rem, n_rem;
    logic [VAL_W-1:0] r_den;
    logic [QUO_W-1:0] r_quo, n_quo;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [VAL_W:0]   shifted;
    logic [VAL_W:0]   diff;

    // remainder stays below den, so the shift never loses a bit
    assign shifted = {r_rem[VAL_W-1:0], 1'b0};
    assign diff    = shifted - {1'b0, r_den};

    always_comb begin
        if (shifted >= {1'b0, r_den}) begin
            n_rem = diff;
            n_quo = {r_quo[QUO_W-2:0], 1'b1};
        end else begin
            n_rem = shifted;
            n_quo = {r_quo[QUO_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {1'b0, i_num};
            r_den <= i_den;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(QUO_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

/* tb/tb.sv */
// testbench: directed and random requests checked against a scoreboard of the axis normalizer
`timescale 1ns / 1ps
module tb;
    import adcn_pkg::*;

    localparam int     N_RANDOM    = 1326;
    localparam int     GEN_CH      = 16;
    localparam int     HOLD_LEN    = 400;
    localparam int     DRAIN_WAIT  = 40;
    localparam int     CYCLE_LIMIT = 600000;
    localparam longint VAL_MAX     = 64'sd2147483647;
    localparam longint VAL_MIN     = -64'sd2147483648;

    logic     i_clk   = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     i_valid = 1'b0;
    t_in_req  i_req   = '0;
    logic     i_stall = 1'b0;
    logic     o_stall;
    logic     o_valid;
    t_out_rsp o_rsp;

    t_in_req  pending_q[$];
    t_out_rsp rsp_expect_q[$];

    int n_requests    = 0;
    int n_accepted    = 0;
    int n_checked     = 0;
    int n_errors      = 0;
    int cycle_cnt     = 0;
    int send_idle_pct = 17;
    int recv_idle_pct = 70;
    int hold_left     = 0;
    bit hold_done     = 1'b0;

    // predicted clip point table
    logic signed [VAL_W-1:0] pt_min[CHANNELS];
    logic signed [VAL_W-1:0] pt_zl[CHANNELS];
    logic signed [VAL_W-1:0] pt_zh[CHANNELS];
    logic signed [VAL_W-1:0] pt_max[CHANNELS];

    // rough per-channel range used only to aim random samples
    longint aim_lo[GEN_CH];
    longint aim_hi[GEN_CH];

    analog_deadzone_clip_normalizer_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_req   (i_req),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .o_rsp   (o_rsp),
        .i_stall (i_stall)
    );

    always #1 i_clk = ~i_clk;

    function automatic longint q16_fraction(longint num, longint den);
        if (den <= 0 || num <= 0) begin
            return 0;
        end
        return (num <<< 16) / den;
    endfunction

    function automatic t_out_rsp normalize_request(t_in_req r);
        t_out_rsp rsp;
        longint   v, mn, zl, zh, mx, res;
        rsp = '{mapped: MAP_ZERO, status: ST_OK};
        res = 0;
        if (r.chan >= CHANNELS) begin
            rsp.status = ST_BAD_CHAN;
        end else if (r.kind == KIND_SAMPLE) begin
            v  = r.sample;
            mn = pt_min[r.chan];
            zl = pt_zl[r.chan];
            zh = pt_zh[r.chan];
            mx = pt_max[r.chan];
            if (v >= zl && v <= zh) begin
                res = 0;
            end else if (v <= mn) begin
                res = MAP_NEG_ONE;
            end else if (v >= mx) begin
                res = MAP_ONE;
            end else if (v > zl) begin
                res = q16_fraction(v - zh, mx - zh);
            end else begin
                res = -q16_fraction(zl - v, zl - mn);
            end
            rsp.mapped = MAP_W'(res);
        end else begin
            if (r.zero_low < r.clip_min || r.zero_high < r.zero_low
                    || r.clip_max < r.zero_high) begin
                rsp.status = ST_BAD_ORDER;
            end else begin
                pt_min[r.chan] = r.clip_min;
                pt_zl[r.chan]  = r.zero_low;
                pt_zh[r.chan]  = r.zero_high;
                pt_max[r.chan] = r.clip_max;
            end
        end
        return rsp;
    endfunction

    // unused fields carry random bits
    function automatic t_in_req load_req(int ch, logic signed [VAL_W-1:0] mn,
            logic signed [VAL_W-1:0] zl, logic signed [VAL_W-1:0] zh,
            logic signed [VAL_W-1:0] mx);
        t_in_req r;
        r.kind      = KIND_LOAD;
        r.chan      = CHAN_W'(ch);
        r.sample    = $urandom;
        r.clip_min  = mn;
        r.zero_low  = zl;
        r.zero_high = zh;
        r.clip_max  = mx;
        return r;
    endfunction

    function automatic t_in_req sample_req(int ch, logic signed [VAL_W-1:0] v);
        t_in_req r;
        r.kind      = KIND_SAMPLE;
        r.chan      = CHAN_W'(ch);
        r.sample    = v;
        r.clip_min  = $urandom;
        r.zero_low  = $urandom;
        r.zero_high = $urandom;
        r.clip_max  = $urandom;
        return r;
    endfunction

    function automatic logic signed [VAL_W-1:0] rand_point(bit wide);
        if (wide) begin
            return $urandom;
        end
        return int'($urandom_range(8 * 65536)) - 4 * 65536;
    endfunction

    initial begin
        logic signed [VAL_W-1:0] pts[4];
        logic signed [VAL_W-1:0] tmp;
        longint                  span, v;
        int                      ch, sel;
        bit                      wide, sorted;

        for (int i = 0; i < CHANNELS; i++) begin
            pt_min[i] = Q16_NEG_ONE;
            pt_zl[i]  = '0;
            pt_zh[i]  = '0;
            pt_max[i] = Q16_ONE;
        end
        for (int i = 0; i < GEN_CH; i++) begin
            aim_lo[i] = -65536;
            aim_hi[i] = 65536;
        end

        // reset points: deadzone, fractions, clip edges and extremes
        pending_q.push_back(sample_req(0, 0));
        pending_q.push_back(sample_req(0, 32768));
        pending_q.push_back(sample_req(0, -32768));
        pending_q.push_back(sample_req(0, 65536));
        pending_q.push_back(sample_req(0, -65536));
        pending_q.push_back(sample_req(0, -1));
        pending_q.push_back(sample_req(0, 1));
        pending_q.push_back(sample_req(0, 32'sh7fffffff));
        pending_q.push_back(sample_req(0, 32'sh80000000));
        // bad channel for both kinds
        pending_q.push_back(sample_req(128, 5));
        pending_q.push_back(load_req(255, -5, 0, 0, 5));
        // each of the three ordering violations
        pending_q.push_back(load_req(3, 10, 5, 6, 7));
        pending_q.push_back(load_req(3, 0, 6, 5, 7));
        pending_q.push_back(load_req(3, 0, 1, 2, 1));
        // full-scale points, divider at its widest
        pending_q.push_back(load_req(127, 32'sh80000000, -1, 0, 32'sh7fffffff));
        pending_q.push_back(sample_req(127, 32'sh80000001));
        pending_q.push_back(sample_req(127, 32'sh7ffffffe));
        pending_q.push_back(sample_req(127, -2));
        pending_q.push_back(sample_req(127, 1));
        pending_q.push_back(sample_req(127, 32'sh80000000));
        // all four points equal
        pending_q.push_back(load_req(1, 5, 5, 5, 5));
        pending_q.push_back(sample_req(1, 5));
        pending_q.push_back(sample_req(1, 6));
        pending_q.push_back(sample_req(1, 4));

        for (int n = 0; n < N_RANDOM; n++) begin
            sel = $urandom_range(99);
            if (sel < 85) begin
                ch = $urandom_range(GEN_CH - 1);
            end else if (sel < 95) begin
                ch = $urandom_range(CHANNELS - 1);
            end else begin
                ch = $urandom_range(255);
            end
            wide = ($urandom_range(99) < 30);
            if ($urandom_range(99) < 25) begin
                for (int i = 0; i < 4; i++) begin
                    pts[i] = rand_point(wide);
                end
                sorted = ($urandom_range(99) >= 10);
                if (sorted) begin
                    for (int i = 0; i < 3; i++) begin
                        for (int j = 0; j < 3 - i; j++) begin
                            if (pts[j] > pts[j + 1]) begin
                                tmp        = pts[j];
                                pts[j]     = pts[j + 1];
                                pts[j + 1] = tmp;
                            end
                        end
                    end
                    // sometimes a deadzone of a single point
                    if ($urandom_range(99) < 15) begin
                        pts[2] = pts[1];
                    end
                    if (ch < GEN_CH) begin
                        aim_lo[ch] = pts[0];
                        aim_hi[ch] = pts[3];
                    end
                end
                pending_q.push_back(load_req(ch, pts[0], pts[1], pts[2], pts[3]));
            end else begin
                if (ch < GEN_CH && $urandom_range(99) < 70) begin
                    span = aim_hi[ch] - aim_lo[ch];
                    v = aim_lo[ch] - span / 8
                        + longint'({$urandom, $urandom} % (span + span / 4 + 1));
                    if (v > VAL_MAX) begin
                        v = VAL_MAX;
                    end
                    if (v < VAL_MIN) begin
                        v = VAL_MIN;
                    end
                    pending_q.push_back(sample_req(ch, VAL_W'(v)));
                end else begin
                    pending_q.push_back(sample_req(ch, rand_point(wide)));
                end
            end
        end
        n_requests = pending_q.size();

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (n_accepted >= n_requests / 3);
        send_idle_pct = 70;
        recv_idle_pct = 17;
        wait (n_accepted >= 2 * n_requests / 3);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        wait (n_accepted == n_requests);
        wait (n_checked == n_requests);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("[analog_deadzone_clip_normalizer_unit] OK");
        end else begin
            $display("[analog_deadzone_clip_normalizer_unit] ERROR");
        end
        $finish;
    end

    // request driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                rsp_expect_q.push_back(normalize_request(i_req));
                n_accepted++;
            end
            if (!i_valid || !o_stall) begin
                if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_req   <= pending_q.pop_front();
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // result receiver: random stalls plus one long hold-off late in the run
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (i_rst_n && !hold_done && n_accepted >= 5 * n_requests / 6) begin
            i_stall   <= 1'b1;
            hold_left <= HOLD_LEN;
            hold_done <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // result monitor
    always @(posedge i_clk) begin : result_monitor
        t_out_rsp want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (rsp_expect_q.size() == 0) begin
                if (n_errors < 10) begin
                    $display("unexpected result: mapped %0d status %0d",
                             o_rsp.mapped, o_rsp.status);
                end
                n_errors++;
            end else begin
                want = rsp_expect_q.pop_front();
                n_checked++;
                if (o_rsp.mapped !== want.mapped || o_rsp.status !== want.status) begin
                    if (n_errors < 10) begin
                        $display("result %0d: expected mapped %0d status %0d, got mapped %0d status %0d",
                                 n_checked, want.mapped, want.status,
                                 o_rsp.mapped, o_rsp.status);
                    end
                    n_errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("[analog_deadzone_clip_normalizer_unit] ERROR");
            $finish;
        end
    end

endmodule

/* filelist.f */
src/adcn_pkg.sv
src/adcn_table.sv
src/adcn_div.sv
src/analog_deadzone_clip_normalizer_unit.sv
tb/tb.sv
